@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on that edge.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions of the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LENGTH_POS = 6'd56;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                     input logic [31:0] g);
    ch = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c);
    maj = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

@@ hdl/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256: absorbs one byte per transfer, emits an 8-word digest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): each transfer carries a
//   command. Absorb appends data_byte to the message; finish pads the
//   message, compresses the final block(s) and produces the digest.
//   Output channel (out_valid / out_stall / out_data): a finish yields eight
//   transfers, digest words 0..7 (most significant first), last_word on 7.
//   Sequence: an absorb writes its byte; the 64th byte of a block starts
//   the compression (64 rounds on one shared round unit, then a fold into
//   the hash words). A finish writes the pad byte, then zero pad bytes up
//   to the length field, then the length field, compresses one or two
//   blocks, then loads the digest words in turn. The round unit sets the
//   sustained rate: no new byte is taken while a block compresses.
//   in_stall is high whenever the sequencer is busy.
//   A stalled receiver holds the output register and, in the digest phase,
//   the sequencer; once the last word is loaded the block takes new input
//   even while that word still waits.
//   Reset loads the initial hash values and clears length and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sha256_stream_hasher
  import sha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire sha_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output sha_out_t      out_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] hash_r [8];
  logic [31:0] hash_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  // Message block as 16 big-endian words; during compression it runs as the
  // sliding message-schedule window with w_r[0] as the current round word.
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        fin_r, fin_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  sha_out_t    out_data_r, out_data_nxt;

  logic        in_fire;
  logic        byte_we;
  logic [7:0]  byte_val;
  logic        len_we;
  logic        go_round;
  logic [4:0]  lane_sh;
  logic [31:0] t1, t2, w_new;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Byte lane 0 of a word is its most significant byte.
  assign lane_sh = {~fill_r[1:0], 3'b000};

  // Shared round unit: one SHA-256 round plus one schedule word per cycle.
  assign t1 = v_r[7] + big_sigma1(v_r[4]) + ch(v_r[4], v_r[5], v_r[6])
            + ROUND_K[round_r] + w_r[0];
  assign t2 = big_sigma0(v_r[0]) + maj(v_r[0], v_r[1], v_r[2]);
  assign w_new = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    v_nxt         = v_r;
    fill_nxt      = fill_r;
    bits_nxt      = bits_r;
    round_nxt     = round_r;
    idx_nxt       = idx_r;
    fin_nxt       = fin_r;
    last_nxt      = last_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    byte_we       = 1'b0;
    byte_val      = 8'h00;
    len_we        = 1'b0;
    go_round      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          byte_we  = 1'b1;
          fill_nxt = fill_r + 6'd1;
          if (in_data.command == CMD_ABSORB) begin
            byte_val = in_data.data_byte;
            bits_nxt = bits_r + 64'd8;
          end else begin
            byte_val  = PAD_BYTE;
            fin_nxt   = 1'b1;
            state_nxt = S_PAD;
          end
          // A full block compresses now; a finish resumes padding after it.
          if (fill_r == LAST_BYTE) begin
            go_round = 1'b1;
          end
        end
      end
      S_PAD: begin
        if (fill_r == LENGTH_POS) begin
          len_we   = 1'b1;
          last_nxt = 1'b1;
          go_round = 1'b1;
        end else begin
          byte_we  = 1'b1;
          fill_nxt = fill_r + 6'd1;
          if (fill_r == LAST_BYTE) begin
            go_round = 1'b1;
          end
        end
      end
      S_ROUND: begin
        for (int i = 7; i > 0; i--) begin
          v_nxt[i] = v_r[i-1];
        end
        v_nxt[4]  = v_r[3] + t1;
        v_nxt[0]  = t1 + t2;
        round_nxt = round_r + 6'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + v_r[i];
        end
        if (last_r) begin
          state_nxt = S_OUT;
        end else if (fin_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.digest_word = hash_r[0];
          out_data_nxt.word_index  = idx_r;
          out_data_nxt.last_word   = (idx_r == LAST_WORD);
          // Rotate so the next word sits at the fixed tap.
          for (int i = 0; i < 7; i++) begin
            hash_nxt[i] = hash_r[i+1];
          end
          hash_nxt[7] = hash_r[0];
          idx_nxt     = idx_r + 3'd1;
          if (idx_r == LAST_WORD) begin
            hash_nxt  = H_INIT;
            bits_nxt  = '0;
            fill_nxt  = '0;
            fin_nxt   = 1'b0;
            last_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_round) begin
      state_nxt = S_ROUND;
      round_nxt = '0;
      v_nxt     = hash_r;
    end
  end

  // Block buffer / schedule window update.
  always_comb begin
    w_nxt = w_r;
    if (state_r == S_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[15] = w_new;
    end else if (byte_we) begin
      w_nxt[fill_r[5:2]][lane_sh +: 8] = byte_val;
    end else if (len_we) begin
      w_nxt[14] = bits_r[63:32];
      w_nxt[15] = bits_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hash_r      <= H_INIT;
      fill_r      <= '0;
      bits_r      <= '0;
      round_r     <= '0;
      idx_r       <= '0;
      fin_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      round_r     <= round_nxt;
      idx_r       <= idx_nxt;
      fin_r       <= fin_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    w_r        <= w_nxt;
    out_data_r <= out_data_nxt;
  end

  // Fill count tracks the byte count between messages.
  `ASSERT_IMPL(a_fill_len, state_r == S_IDLE, bits_r[8:3] == fill_r, "fill count off length")
  // Every compression starts at round zero.
  `ASSERT_IMPL(a_round_start, state_r == S_ROUND && $past(state_r) != S_ROUND, round_r == '0, "round start")
  // Digest words appear only from the output phase.
  `ASSERT_IMPL(a_out_src, $rose(out_valid_r), $past(state_r) == S_OUT, "output loaded outside digest phase")
  // A stalled digest word stays valid and unchanged.
  `ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_data_r), "stalled output changed")

endmodule

`default_nettype wire

@@ verif/sha256_stream_hasher_tb.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Self-checking bench for the streaming SHA-256 hasher. Drives byte absorbs
// and finish commands, predicts every digest word with its own SHA-256
// engine, and compares each output transfer field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_tb
  import sha_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned TARGET_ITEMS   = 350;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned REPORT_LIMIT   = 10;

  // --------------------------------------------------------------------------
  // Digest predictor and in-order checker
  // --------------------------------------------------------------------------
  class sha256_scoreboard;
    logic [31:0] chain [8];
    logic [7:0]  block_bytes [64];
    int unsigned fill;
    logic [63:0] bit_count;
    sha_out_t    pending_digest [$];
    int unsigned mismatches;
    int unsigned unexpected;
    int unsigned words_checked;
    int unsigned messages_done;
    int unsigned bytes_absorbed;

    function new();
      start_message();
    endfunction

    function void start_message();
      foreach (chain[k]) chain[k] = H_INIT[k];
      fill      = 0;
      bit_count = '0;
    endfunction

    function logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return 32'({x, x} >> n);
    endfunction

    // One 64-round compression of block_bytes into the chaining value.
    function void compress();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
        w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0   = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
        s1   = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                  chain[4], chain[5], chain[6], chain[7]};
      for (int i = 0; i < 64; i++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_K[i] + w[i];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g;
        g = f;
        f = e;
        e = d + t1;
        d = c;
        c = b;
        b = a;
        a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Accepted input transfer: absorb a byte, or pad, close and queue the digest.
    function void note_input(input sha_in_t item);
      sha_out_t word;
      if (item.command == CMD_ABSORB) begin
        block_bytes[fill] = item.data_byte;
        fill++;
        bit_count += 64'd8;
        bytes_absorbed++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end else begin
        block_bytes[fill] = PAD_BYTE;
        fill++;
        // No room left for the length field: flush an extra padded block.
        if (fill > LENGTH_POS) begin
          for (int k = fill; k < 64; k++) block_bytes[k] = 8'h00;
          compress();
          fill = 0;
        end
        for (int k = fill; k < LENGTH_POS; k++) block_bytes[k] = 8'h00;
        for (int k = 0; k < 8; k++) block_bytes[LENGTH_POS + k] = bit_count[63 - 8*k -: 8];
        compress();
        for (int k = 0; k < 8; k++) begin
          word.digest_word = chain[k];
          word.word_index  = 3'(k);
          word.last_word   = (3'(k) == LAST_WORD);
          pending_digest   = {pending_digest, word};
        end
        messages_done++;
        start_message();
      end
    endfunction

    function void report(input string what, input logic [31:0] want, input logic [31:0] got);
      if (mismatches + unexpected <= REPORT_LIMIT)
        $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    // Accepted output transfer: compare with the oldest predicted word.
    function void check_result(input sha_out_t got);
      sha_out_t want;
      if (pending_digest.size() == 0) begin
        unexpected++;
        report("digest word with none pending", '0, got.digest_word);
        return;
      end
      want = pending_digest.pop_front();
      words_checked++;
      if (got.digest_word !== want.digest_word) begin
        mismatches++;
        report($sformatf("digest_word[%0d]", want.word_index), want.digest_word,
               got.digest_word);
      end
      if (got.word_index !== want.word_index) begin
        mismatches++;
        report("word_index", 32'(want.word_index), 32'(got.word_index));
      end
      if (got.last_word !== want.last_word) begin
        mismatches++;
        report($sformatf("last_word[%0d]", want.word_index), 32'(want.last_word),
               32'(got.last_word));
      end
    endfunction

    function int unsigned error_count();
      return mismatches + unexpected + pending_digest.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  sha_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sha_out_t out_data;

  always #10 clk = ~clk;

  sha256_stream_hasher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sha256_scoreboard sb = new();

  // Idle odds in percent, changed by phase from the stimulus process.
  int unsigned sender_idle_pct   = 18;
  int unsigned receiver_idle_pct = 71;
  int unsigned items_pushed      = 0;
  int unsigned quiet_cycles      = 0;
  bit          receiver_hold_done = 1'b0;

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Count edges with no transfer on either channel; the watchdog reads it.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL sha256_stream_hasher");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall at the falling edge. After the first digest,
  // hold off for a long stretch so the next finish backs up into the input.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (!receiver_hold_done && sb.words_checked >= 8) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        receiver_hold_done = 1'b1;
      end
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offer one item, idling at random first; return at the falling edge after
  // the transfer. Valid stays high into the next item unless it idles.
  task automatic push_item(input logic command, input logic [7:0] data_byte);
    sha_in_t item;
    item.command   = command;
    item.data_byte = data_byte;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_pushed++;
  endtask

  // Absorb len bytes (all zero, all ones or random), then finish with a random (ignored) byte.
  task automatic push_message(input int unsigned len);
    int unsigned fill_style;
    fill_style = $urandom_range(9);
    for (int unsigned i = 0; i < len; i++) begin
      unique case (fill_style)
        0:       push_item(CMD_ABSORB, 8'h00);
        1:       push_item(CMD_ABSORB, 8'hff);
        default: push_item(CMD_ABSORB, 8'($urandom));
      endcase
    end
    push_item(CMD_FINISH, 8'($urandom));
  endtask

  // Lengths that put the pad byte and length field right at block edges.
  int unsigned edge_lengths [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  initial begin
    int unsigned len;

    // Hold reset, then release it at a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty message twice (finish byte ignored), "abc", then
    // extreme byte values in short messages.
    push_item(CMD_FINISH, 8'h00);
    push_item(CMD_FINISH, 8'hff);
    push_item(CMD_ABSORB, 8'h61);
    push_item(CMD_ABSORB, 8'h62);
    push_item(CMD_ABSORB, 8'h63);
    push_item(CMD_FINISH, 8'h5a);
    push_item(CMD_ABSORB, 8'h00);
    push_item(CMD_ABSORB, 8'hff);
    push_item(CMD_FINISH, 8'ha5);
    push_item(CMD_ABSORB, 8'h80);
    push_item(CMD_ABSORB, 8'h7f);
    push_item(CMD_ABSORB, 8'h01);
    push_item(CMD_FINISH, 8'h00);

    // Random messages; swap idle odds by thirds, last third runs flat out.
    while (items_pushed < TARGET_ITEMS) begin
      if (items_pushed >= 2 * TARGET_ITEMS / 3) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end else if (items_pushed >= TARGET_ITEMS / 3) begin
        sender_idle_pct   = 71;
        receiver_idle_pct = 18;
      end
      if ($urandom_range(99) < 30)
        len = edge_lengths[$urandom_range(9)];
      else
        len = $urandom_range(0, 24);
      push_message(len);
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted word, then watch for strays.
    while (sb.pending_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d absorbed bytes; %0d digest words checked.",
             sb.messages_done, sb.bytes_absorbed, sb.words_checked);
    $display("Included empty and block-edge lengths, a long output hold and three idle mixes.");
    if (sb.error_count() == 0) begin
      $display("PASS sha256_stream_hasher");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing words",
               sb.mismatches, sb.unexpected, sb.pending_digest.size());
      $display("FAIL sha256_stream_hasher");
    end
    $finish;
  end

endmodule

`default_nettype wire
